/* hw/rtl/bps_pkg.sv */
// Shared types, constants and colour select function for the background pixel smoother.
package bps_pkg;

	localparam int LINE_PAIRS_DEF = 256;
	localparam int TABLE_AW       = 10;
	localparam int TABLE_DEPTH    = 1 << TABLE_AW;

	typedef enum logic [1:0] {
		REQ_PIXEL  = 2'd0,
		REQ_HWRITE = 2'd1,
		REQ_VWRITE = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	// Pixel colour, MSB first: A high nibble, A low nibble, B high nibble, B low nibble.
	function automatic logic [3:0] pick_colour(input logic [7:0] a, input logic [7:0] b,
			input logic [1:0] sel);
		logic [2:0] hi;
		logic [1:0] lo;
		hi = 3'd7 - {1'b0, sel};
		lo = 2'd3 - sel;
		return {a[hi], a[{1'b0, lo}], b[hi], b[{1'b0, lo}]};
	endfunction

endpackage

/* hw/rtl/bps_line_store.sv */
// Previous-line store with write-to-read forwarding and a clearing pass after reset.
module bps_line_store import bps_pkg::*; #(
	parameter int LINE_PAIRS = LINE_PAIRS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(LINE_PAIRS)-1:0] rd_addr,
	output logic [7:0]                    rd_data,
	input  logic                          wr_en,
	input  logic [$clog2(LINE_PAIRS)-1:0] wr_addr,
	input  logic [7:0]                    wr_data,
	output logic                          busy
);

	localparam int IDX_W = $clog2(LINE_PAIRS);

	logic [7:0]       mem [LINE_PAIRS];
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic [7:0]       rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (clr_addr_q == IDX_W'(LINE_PAIRS - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mem[clr_addr_q] <= 8'd0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// a write landing on the entry being read in the same cycle is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr)
				rd_data_q <= wr_data;
			else
				rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

endmodule

/* hw/rtl/background_pixel_smoother.sv */
// Top level of the background pixel smoother: colour select, smoothing tables, output stage.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid / in_stall       req_type .. gfx_byte_b
//  out      source     out_valid / out_stall     pixel_even, pixel_odd
//  cfg      sink       cfg_valid / cfg_ready     table_select
//
// One request per cycle while in_stall is low. The horizontal table and line store are
// read on acceptance into the middle stage, the vertical table as a pair enters the output
// register. After reset the line store is cleared entry by entry, with in_stall held high.
// out_stall holds the output register; the middle stage still takes a request while the
// output waits, and outside the clearing pass in_stall rises only when both stages are full.
module background_pixel_smoother import bps_pkg::*; #(
	parameter int LINE_PAIRS = LINE_PAIRS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [9:0] table_addr,
	input  logic [3:0] table_data,
	input  logic [7:0] pair_index,
	input  logic       line_start,
	input  logic       first_line,
	input  logic [3:0] scrolled_x_low,
	input  logic       flip_x,
	input  logic [7:0] gfx_byte_a,
	input  logic [7:0] gfx_byte_b,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] pixel_even,
	output logic [3:0] pixel_odd,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] table_select
);

	localparam int IDX_W = $clog2(LINE_PAIRS);

	logic [3:0]          htable [TABLE_DEPTH];
	logic [3:0]          vtable [TABLE_DEPTH];

	logic [1:0]          bank_q;
	logic [3:0]          prev_colour_q;

	logic [3:0]          sx_eff;
	logic [3:0]          colour;
	logic [3:0]          prev;
	logic [TABLE_AW-1:0] haddr;
	logic [15:0]         idx_full;
	logic [IDX_W-1:0]    idx;

	logic                en1;
	logic                en2;
	logic                accept;
	logic                pix_acc;
	logic                ls_busy;

	logic                valid_s1;
	logic [3:0]          col_s1;
	logic [3:0]          smooth_s1;
	logic                fline_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [7:0]          ls_rd_s1;
	logic [7:0]          above_s1;
	logic [TABLE_AW-1:0] vaddr_even;
	logic [TABLE_AW-1:0] vaddr_odd;

	logic                valid_s2;
	logic [3:0]          even_s2;
	logic [3:0]          odd_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bank_q <= 2'd0;
		else if (cfg_valid)
			bank_q <= table_select;
	end

	always_comb begin
		sx_eff = scrolled_x_low ^ {4{flip_x}};
		colour = pick_colour(gfx_byte_a, gfx_byte_b, sx_eff[2:1]);
		prev   = line_start ? 4'd0 : prev_colour_q;
		haddr  = {bank_q, prev, colour};
	end

	// pair index modulo LINE_PAIRS by restoring subtraction, exact for LINE_PAIRS of 16 or more
	always_comb begin
		idx_full = {8'd0, pair_index};
		for (int k = 3; k >= 0; k--) begin
			if (idx_full >= 16'(LINE_PAIRS << k))
				idx_full = idx_full - 16'(LINE_PAIRS << k);
		end
		idx = idx_full[IDX_W-1:0];
	end

	assign en2      = !valid_s2 || !out_stall;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1 || ls_busy;
	assign accept   = in_valid && !in_stall;
	assign pix_acc  = accept && (req_type == REQ_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prev_colour_q <= 4'd0;
		else if (pix_acc)
			prev_colour_q <= colour;
	end

	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_HWRITE)
			htable[table_addr] <= table_data;
		if (pix_acc)
			smooth_s1 <= htable[haddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en1)
			valid_s1 <= pix_acc;
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			col_s1   <= colour;
			fline_s1 <= first_line;
			idx_s1   <= idx;
		end
	end

	bps_line_store #(
		.LINE_PAIRS(LINE_PAIRS)
	) u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (pix_acc),
		.rd_addr(idx),
		.rd_data(ls_rd_s1),
		.wr_en  (valid_s1 && en2),
		.wr_addr(idx_s1),
		.wr_data({col_s1, smooth_s1}),
		.busy   (ls_busy)
	);

	always_comb begin
		above_s1   = fline_s1 ? 8'd0 : ls_rd_s1;
		vaddr_even = {bank_q, above_s1[3:0], smooth_s1};
		vaddr_odd  = {bank_q, above_s1[7:4], col_s1};
	end

	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_VWRITE)
			vtable[table_addr] <= table_data;
		if (valid_s1 && en2) begin
			even_s2 <= vtable[vaddr_even];
			odd_s2  <= vtable[vaddr_odd];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en2)
			valid_s2 <= valid_s1;
	end

	assign out_valid  = valid_s2;
	assign pixel_even = even_s2;
	assign pixel_odd  = odd_s2;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the background pixel smoother: directed rows, then random line traffic.
`timescale 1ns / 1ps

module testbench;
	import bps_pkg::*;

	localparam int CLK_HALF  = 5;
	localparam int TIMEOUT   = 600000;
	localparam int DRAIN     = 8;
	localparam int PHASES    = 4;
	localparam int PHASE_REQ = 45;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		req_type_t  req;
		logic [9:0] taddr;
		logic [3:0] tdata;
		logic [7:0] idx;
		logic       lstart;
		logic       fline;
		logic [3:0] sx;
		logic       flip;
		logic [7:0] a;
		logic [7:0] b;
		logic       typed;
		logic [3:0] want_even;
		logic [3:0] want_odd;
	} pair_req_t;

	typedef struct packed {
		logic [3:0] even;
		logic [3:0] odd;
	} pen_pair_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] req_type;
	logic [9:0] table_addr;
	logic [3:0] table_data;
	logic [7:0] pair_index;
	logic       line_start;
	logic       first_line;
	logic [3:0] scrolled_x_low;
	logic       flip_x;
	logic [7:0] gfx_byte_a;
	logic [7:0] gfx_byte_b;
	logic       out_valid;
	logic       out_stall;
	logic [3:0] pixel_even;
	logic [3:0] pixel_odd;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] table_select;

	// shadow copy of the block state
	logic [3:0] hor_prom  [0:TABLE_DEPTH-1];
	logic [3:0] vert_prom [0:TABLE_DEPTH-1];
	logic [7:0] line_mem  [0:255];
	logic [3:0] last_colour;
	logic [1:0] bank;

	pen_pair_t pending_pens[$];
	pen_pair_t got_pens;
	int        errors;
	int        pens_seen;
	int        cycles;
	bit        calm;

	background_pixel_smoother u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.table_addr     (table_addr),
		.table_data     (table_data),
		.pair_index     (pair_index),
		.line_start     (line_start),
		.first_line     (first_line),
		.scrolled_x_low (scrolled_x_low),
		.flip_x         (flip_x),
		.gfx_byte_a     (gfx_byte_a),
		.gfx_byte_b     (gfx_byte_b),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_even     (pixel_even),
		.pixel_odd      (pixel_odd),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.table_select   (table_select)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic pair_req_t pix(input logic [7:0] idx, input logic ls, input logic fl,
			input logic [3:0] sx, input logic fx, input logic [7:0] a, input logic [7:0] b);
		pair_req_t r;
		r        = '0;
		r.req    = REQ_PIXEL;
		r.idx    = idx;
		r.lstart = ls;
		r.fline  = fl;
		r.sx     = sx;
		r.flip   = fx;
		r.a      = a;
		r.b      = b;
		return r;
	endfunction

	function automatic pair_req_t wr(input req_type_t kind, input logic [9:0] addr,
			input logic [3:0] data);
		pair_req_t r;
		r       = '0;
		r.req   = kind;
		r.taddr = addr;
		r.tdata = data;
		return r;
	endfunction

	function automatic pair_req_t rand_pix(input logic [7:0] idx, input logic ls,
			input logic fl);
		return pix(idx, ls, fl, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endfunction

	// update the shadow state and queue the pens a pixel pair should produce
	task automatic track_request(input pair_req_t r);
		logic [3:0] sx;
		logic [1:0] sel;
		logic [3:0] col;
		logic [3:0] prev;
		logic [3:0] smooth;
		logic [7:0] above;
		pen_pair_t  p;
		case (r.req)
			REQ_HWRITE: hor_prom[r.taddr] = r.tdata;
			REQ_VWRITE: vert_prom[r.taddr] = r.tdata;
			REQ_PIXEL: begin
				sx     = r.flip ? ~r.sx : r.sx;
				sel    = sx[2:1];
				col    = {r.a[7 - sel], r.a[3 - sel], r.b[7 - sel], r.b[3 - sel]};
				prev   = r.lstart ? 4'd0 : last_colour;
				smooth = hor_prom[{bank, prev, col}];
				above  = r.fline ? 8'd0 : line_mem[r.idx];
				p.even = vert_prom[{bank, above[3:0], smooth}];
				p.odd  = vert_prom[{bank, above[7:4], col}];
				if (r.typed) begin
					p.even = r.want_even;
					p.odd  = r.want_odd;
				end
				line_mem[r.idx] = {col, smooth};
				last_colour     = col;
				pending_pens.push_back(p);
			end
			default: ;
		endcase
	endtask

	task automatic send_req(input pair_req_t r);
		in_valid       <= 1'b1;
		req_type       <= r.req;
		table_addr     <= r.taddr;
		table_data     <= r.tdata;
		pair_index     <= r.idx;
		line_start     <= r.lstart;
		first_line     <= r.fline;
		scrolled_x_low <= r.sx;
		flip_x         <= r.flip;
		gfx_byte_a     <= r.a;
		gfx_byte_b     <= r.b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_request(r);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16))
				@(posedge clk);
		end
	endtask

	// bank change only once the pipeline has drained
	task automatic set_bank(input logic [1:0] v);
		in_valid <= 1'b0;
		while (pending_pens.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		cfg_valid    <= 1'b1;
		table_select <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		bank = v;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pens.size() == 0) begin
				$error("unexpected pixel pair: pixel_even %0d pixel_odd %0d",
					pixel_even, pixel_odd);
				errors++;
			end else begin
				got_pens = pending_pens.pop_front();
				if (pixel_even !== got_pens.even) begin
					$error("pixel_even: expected %0d, got %0d", got_pens.even, pixel_even);
					errors++;
				end
				if (pixel_odd !== got_pens.odd) begin
					$error("pixel_odd: expected %0d, got %0d", got_pens.odd, pixel_odd);
					errors++;
				end
				pens_seen++;
			end
		end
	end

	initial begin : receiver
		bit held_long;
		held_long = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_long && pens_seen >= 40) begin
				held_long = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD)
					@(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16))
					@(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		pair_req_t rows[$];
		pair_req_t r;
		int        sent;
		int        n_lines;
		int        len;
		int        pick;
		logic [7:0] base;
		bit        fresh;
		logic [1:0] phase_bank [0:PHASES-1];

		errors      = 0;
		pens_seen   = 0;
		cycles      = 0;
		calm        = 1'b0;
		bank        = 2'd0;
		last_colour = 4'd0;
		for (int i = 0; i < 256; i++)
			line_mem[i] = 8'd0;

		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		req_type       <= REQ_NONE;
		table_addr     <= '0;
		table_data     <= '0;
		pair_index     <= '0;
		line_start     <= 1'b0;
		first_line     <= 1'b0;
		scrolled_x_low <= '0;
		flip_x         <= 1'b0;
		gfx_byte_a     <= '0;
		gfx_byte_b     <= '0;
		cfg_valid      <= 1'b0;
		table_select   <= '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_bank(2'd0);

		// load banks 0 and 3 of both tables; only those banks are ever selected
		for (int i = 0; i < 256; i++) begin
			send_req(wr(REQ_HWRITE, {2'd0, 8'(i)}, 4'($urandom_range(0, 15))));
			send_req(wr(REQ_VWRITE, {2'd0, 8'(i)}, 4'($urandom_range(0, 15))));
			send_req(wr(REQ_HWRITE, {2'd3, 8'(i)}, 4'($urandom_range(0, 15))));
			send_req(wr(REQ_VWRITE, {2'd3, 8'(i)}, 4'($urandom_range(0, 15))));
		end

		rows.push_back(wr(REQ_HWRITE, 10'h000, 4'd5));
		rows.push_back(wr(REQ_VWRITE, 10'h005, 4'd9));
		rows.push_back(wr(REQ_VWRITE, 10'h000, 4'd3));
		r = pix(8'd0, 1'b1, 1'b1, 4'h0, 1'b0, 8'h00, 8'h00);
		r.typed = 1'b1; r.want_even = 4'd9; r.want_odd = 4'd3;
		rows.push_back(r);
		rows.push_back(wr(REQ_HWRITE, 10'h00f, 4'ha));
		rows.push_back(wr(REQ_VWRITE, 10'h00a, 4'h6));
		rows.push_back(wr(REQ_VWRITE, 10'h00f, 4'hc));
		r = pix(8'd255, 1'b1, 1'b1, 4'hf, 1'b1, 8'hff, 8'hff);
		r.typed = 1'b1; r.want_even = 4'h6; r.want_odd = 4'hc;
		rows.push_back(r);
		rows.push_back(pix(8'd0, 1'b0, 1'b0, 4'h3, 1'b0, 8'ha5, 8'h3c));
		r = pix(8'd255, 1'b0, 1'b0, 4'h4, 1'b1, 8'h5a, 8'hc3);
		r.req = REQ_NONE; r.taddr = 10'h3ff; r.tdata = 4'hf;
		rows.push_back(r);
		rows.push_back(pix(8'd1, 1'b0, 1'b0, 4'h2, 1'b0, 8'ha5, 8'h3c));
		rows.push_back(pix(8'd2, 1'b0, 1'b0, 4'h5, 1'b1, 8'ha5, 8'h3c));
		rows.push_back(pix(8'd3, 1'b0, 1'b0, 4'h6, 1'b0, 8'ha5, 8'h3c));
		rows.push_back(pix(8'd255, 1'b0, 1'b0, 4'h9, 1'b0, 8'h0f, 8'hf0));
		rows.push_back(wr(REQ_HWRITE, 10'h3ff, 4'hf));
		rows.push_back(wr(REQ_VWRITE, 10'h3ff, 4'h0));
		rows.push_back(pix(8'd128, 1'b1, 1'b0, 4'ha, 1'b1, 8'h81, 8'h18));
		rows.push_back(pix(8'd129, 1'b0, 1'b1, 4'hd, 1'b0, 8'h7e, 8'he7));
		foreach (rows[i])
			send_req(rows[i]);

		phase_bank[0] = 2'd3;
		phase_bank[1] = 2'd0;
		phase_bank[2] = 2'd3;
		phase_bank[3] = 2'd0;

		for (int ph = 0; ph < PHASES; ph++) begin
			set_bank(phase_bank[ph]);
			if (ph == PHASES - 1)
				calm = 1'b1;
			sent = 0;
			while (sent < PHASE_REQ) begin
				pick = $urandom_range(0, 99);
				if (pick < 75) begin
					// a few raster lines of well-formed pairs
					n_lines = $urandom_range(1, 4);
					len     = $urandom_range(2, 24);
					base    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
					fresh   = $urandom_range(0, 2) != 0;
					for (int l = 0; l < n_lines; l++)
						for (int p = 0; p < len; p++) begin
							send_req(rand_pix(base + 8'(p), p == 0, fresh && l == 0));
							sent++;
						end
				end else if (pick < 85) begin
					send_req(wr(($urandom_range(0, 1) != 0) ? REQ_HWRITE : REQ_VWRITE,
						10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15))));
					sent++;
				end else if (pick < 95) begin
					send_req(rand_pix(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1))));
					sent++;
				end else begin
					r       = rand_pix(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					r.req   = REQ_NONE;
					r.taddr = 10'($urandom_range(0, 1023));
					r.tdata = 4'($urandom_range(0, 15));
					send_req(r);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_pens.size() != 0)
			@(posedge clk);
		repeat (DRAIN)
			@(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
